// ===== hdl/voxel_background_model_assert.svh =====
// assertion macros for the voxel background model
`ifndef VOXEL_BACKGROUND_MODEL_ASSERT_SVH
`define VOXEL_BACKGROUND_MODEL_ASSERT_SVH

// checked on every clock edge outside reset
`define VBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define VBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/vbm_pkg.sv =====
// shared types and constants of the voxel background model
package vbm_pkg;

  localparam int unsigned MaxVoxels = 32768;
  localparam int unsigned IdxW      = $clog2(MaxVoxels);
  localparam int unsigned CoordW    = 20;
  localparam int unsigned ResW      = 16;
  localparam int unsigned GridW     = 11;
  localparam int unsigned CntW      = 16;
  localparam int unsigned DivSteps  = CoordW;
  localparam int unsigned StepW     = $clog2(DivSteps);
  localparam int unsigned NumAxes   = 3;

  localparam logic signed [CoordW-1:0] RegionXMin = -20'sd2000;
  localparam logic signed [CoordW-1:0] RegionYMin = -20'sd5700;
  localparam logic signed [CoordW-1:0] RegionZMin = 20'sd45000;

  typedef enum logic [1:0] {
    REQ_LEARN    = 2'd0,
    REQ_EOF      = 2'd1,
    REQ_CLASSIFY = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_RESOLUTION = 3'd3,
    CFG_GRID_X     = 3'd4,
    CFG_GRID_Y     = 3'd5,
    CFG_GRID_Z     = 3'd6,
    CFG_THRESHOLD  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic [ResW-1:0]          resolution;
    logic [GridW-1:0]         grid_x;
    logic [GridW-1:0]         grid_y;
    logic [GridW-1:0]         grid_z;
  } geom_t;

  typedef struct packed {
    req_e            op;
    logic [IdxW-1:0] idx;
  } vox_op_t;

endpackage

// ===== hdl/vbm_ram.sv =====
// single-port-write, registered-read generic ram
module vbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/vbm_front.sv =====
// front end: accepts beats, screens them and turns points into voxel indexes
module vbm_front import vbm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  geom_t                    geom_i,
  input  logic                     en_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [1:0]               req_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic signed [CoordW-1:0] pz_i,
  output logic                     push_o,
  output vox_op_t                  op_o,
  input  logic                     full_i
);

  typedef enum logic [5:0] {
    FS_IDLE  = 6'b000001,
    FS_DIV   = 6'b000010,
    FS_CLAMP = 6'b000100,
    FS_MUL1  = 6'b001000,
    FS_MUL2  = 6'b010000,
    FS_PUSH  = 6'b100000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  req_e              op_q, op_d;

  logic [CoordW-1:0] dvd_q [NumAxes];
  logic [CoordW-1:0] dvd_d [NumAxes];
  logic [ResW-1:0]   rem_q [NumAxes];
  logic [ResW-1:0]   rem_d [NumAxes];
  logic [GridW-1:0]  ax_q  [NumAxes];
  logic [GridW-1:0]  ax_d  [NumAxes];

  logic [IdxW-1:0] gxz_q, gxz_d, p1_q, p1_d, p2_q, p2_d, s1_q, s1_d;

  logic signed [CoordW-1:0] coord  [NumAxes];
  logic signed [CoordW-1:0] origin [NumAxes];
  logic [GridW-1:0]         nm1    [NumAxes];
  logic [ResW-1:0]          res_eff;
  logic [GridW-1:0]         gx_eff, gz_eff;
  logic                     accept, in_region;
  req_e                     req;

  logic signed [CoordW:0]   diff  [NumAxes];
  logic [ResW:0]            trial [NumAxes];
  logic [ResW:0]            sub   [NumAxes];
  logic                     ge    [NumAxes];
  logic [2*GridW-1:0]       prod_gxz, prod_p1;
  logic [IdxW+GridW-1:0]    prod_p2;

  assign coord[0]  = px_i;
  assign coord[1]  = py_i;
  assign coord[2]  = pz_i;
  assign origin[0] = geom_i.origin_x;
  assign origin[1] = geom_i.origin_y;
  assign origin[2] = geom_i.origin_z;

  // zero sizes behave as one
  assign res_eff = (geom_i.resolution == '0) ? ResW'(1) : geom_i.resolution;
  assign gx_eff  = (geom_i.grid_x == '0) ? GridW'(1) : geom_i.grid_x;
  assign gz_eff  = (geom_i.grid_z == '0) ? GridW'(1) : geom_i.grid_z;
  assign nm1[0]  = (geom_i.grid_x == '0) ? '0 : geom_i.grid_x - GridW'(1);
  assign nm1[1]  = (geom_i.grid_y == '0) ? '0 : geom_i.grid_y - GridW'(1);
  assign nm1[2]  = (geom_i.grid_z == '0) ? '0 : geom_i.grid_z - GridW'(1);

  assign req       = req_e'(req_i);
  assign ready_o   = (state_q == FS_IDLE) && en_i;
  assign accept    = valid_i && ready_o;
  assign in_region = (px_i > RegionXMin) && ((py_i > RegionYMin) || (pz_i > RegionZMin));

  assign prod_gxz = gx_eff * gz_eff;
  assign prod_p1  = ax_q[0] * gz_eff;
  assign prod_p2  = gxz_q * ax_q[1];

  assign push_o = (state_q == FS_PUSH) && !full_i;
  assign op_o   = '{op: op_q, idx: p2_q + s1_q};

  always_comb begin
    for (int l = 0; l < NumAxes; l++) begin
      diff[l]  = {coord[l][CoordW-1], coord[l]} - {origin[l][CoordW-1], origin[l]};
      // one restoring step: quotient bits shift into the dividend register
      trial[l] = {rem_q[l], dvd_q[l][CoordW-1]};
      ge[l]    = trial[l] >= {1'b0, res_eff};
      sub[l]   = trial[l] - {1'b0, res_eff};
      ax_d[l]  = ax_q[l];
      rem_d[l] = rem_q[l];
      dvd_d[l] = dvd_q[l];
    end
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    gxz_d   = gxz_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    s1_d    = s1_q;

    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          op_d   = req;
          step_d = '0;
          for (int l = 0; l < NumAxes; l++) begin
            rem_d[l] = '0;
            // offset at or below origin quantizes to zero
            dvd_d[l] = (!diff[l][CoordW] && (diff[l] != '0)) ? diff[l][CoordW-1:0] : '0;
          end
          if (req == REQ_EOF) begin
            state_d = FS_PUSH;
          end else if (req == REQ_LEARN || (req == REQ_CLASSIFY && in_region)) begin
            state_d = FS_DIV;
          end
        end
      end
      FS_DIV: begin
        for (int l = 0; l < NumAxes; l++) begin
          rem_d[l] = ge[l] ? sub[l][ResW-1:0] : trial[l][ResW-1:0];
          dvd_d[l] = {dvd_q[l][CoordW-2:0], ge[l]};
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = FS_CLAMP;
        end
      end
      FS_CLAMP: begin
        for (int l = 0; l < NumAxes; l++) begin
          ax_d[l] = (dvd_q[l] > CoordW'(nm1[l])) ? nm1[l] : dvd_q[l][GridW-1:0];
        end
        state_d = FS_MUL1;
      end
      FS_MUL1: begin
        gxz_d   = prod_gxz[IdxW-1:0];
        p1_d    = prod_p1[IdxW-1:0];
        state_d = FS_MUL2;
      end
      FS_MUL2: begin
        p2_d    = prod_p2[IdxW-1:0];
        s1_d    = p1_q + IdxW'(ax_q[2]);
        state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!full_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      step_q  <= '0;
      op_q    <= REQ_LEARN;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumAxes; l++) begin
      dvd_q[l] <= dvd_d[l];
      rem_q[l] <= rem_d[l];
      ax_q[l]  <= ax_d[l];
    end
    gxz_q <= gxz_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    s1_q  <= s1_d;
  end

endmodule

// ===== hdl/vbm_queue.sv =====
// two-entry queue between front end and back end
module vbm_queue import vbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  vox_op_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output vox_op_t data_o,
  output logic    empty_o
);

  vox_op_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/vbm_back.sv =====
// back end: count and frame-mark memories, clearing sweeps, result register
module vbm_back import vbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] threshold_i,
  input  vox_op_t         op_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            init_done_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            bg_o,
  output logic [IdxW-1:0] idx_o
);

  typedef enum logic [4:0] {
    BS_CLEAR  = 5'b00001,
    BS_IDLE   = 5'b00010,
    BS_READ   = 5'b00100,
    BS_RESULT = 5'b01000,
    BS_HOLD   = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic            clr_all_q, clr_all_d;
  logic            init_q, init_d;
  vox_op_t         cur_q, cur_d;
  logic            bg_q, bg_d;
  logic            ov_q, ov_d, obg_q, obg_d;
  logic [IdxW-1:0] oidx_q, oidx_d;

  logic            cnt_we, seen_we, seen_wd, seen_rd;
  logic [IdxW-1:0] waddr;
  logic [CntW-1:0] cnt_wd, cnt_rd;
  logic            out_free;

  vbm_ram #(.Width(CntW), .Depth(MaxVoxels)) u_count (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(waddr),
    .wdata_i(cnt_wd),
    .raddr_i(op_i.idx),
    .rdata_o(cnt_rd)
  );

  vbm_ram #(.Width(1), .Depth(MaxVoxels)) u_seen (
    .clk_i  (clk_i),
    .we_i   (seen_we),
    .waddr_i(waddr),
    .wdata_i(seen_wd),
    .raddr_i(op_i.idx),
    .rdata_o(seen_rd)
  );

  assign out_free    = !ov_q || ready_i;
  assign valid_o     = ov_q;
  assign bg_o        = obg_q;
  assign idx_o       = oidx_q;
  assign init_done_o = init_q;
  assign waddr       = (state_q == BS_CLEAR) ? clr_q : cur_q.idx;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clr_all_d = clr_all_q;
    init_d    = init_q;
    cur_d     = cur_q;
    bg_d      = bg_q;
    ov_d      = ov_q && !ready_i;
    obg_d     = obg_q;
    oidx_d    = oidx_q;
    pop_o     = 1'b0;
    cnt_we    = 1'b0;
    cnt_wd    = '0;
    seen_we   = 1'b0;
    seen_wd   = 1'b0;

    case (state_q)
      BS_CLEAR: begin
        seen_we = 1'b1;
        cnt_we  = clr_all_q;
        clr_d   = clr_q + IdxW'(1);
        if (clr_q == '1) begin
          init_d  = 1'b1;
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = op_i;
          if (op_i.op == REQ_EOF) begin
            clr_d     = '0;
            clr_all_d = 1'b0;
            state_d   = BS_CLEAR;
          end else begin
            state_d = BS_READ;
          end
        end
      end
      BS_READ: begin
        if (cur_q.op == REQ_CLASSIFY) begin
          bg_d    = cnt_rd > threshold_i;
          state_d = BS_RESULT;
        end else begin
          // learn: once per frame, saturating
          if (!seen_rd) begin
            cnt_we  = 1'b1;
            cnt_wd  = (cnt_rd == '1) ? cnt_rd : cnt_rd + CntW'(1);
            seen_we = 1'b1;
            seen_wd = 1'b1;
          end
          state_d = BS_IDLE;
        end
      end
      BS_RESULT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          obg_d   = bg_q;
          oidx_d  = cur_q.idx;
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_CLEAR;
      clr_q     <= '0;
      clr_all_q <= 1'b1;
      init_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_all_q <= clr_all_d;
      init_q    <= init_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    bg_q   <= bg_d;
    obg_q  <= obg_d;
    oidx_q <= oidx_d;
  end

endmodule

// ===== hdl/voxel_background_model.sv =====
// top level of the voxel background model
// A learn or classify point passes the 20-step restoring divider of the front end
// (one per axis, the three axes in parallel) and its clamp and multiply states,
// then reads the count memory in the back end; a two-entry queue lets the two
// overlap. An end-of-frame beat sweeps the frame-mark memory in the back end,
// while the front end keeps taking points into the queue until it is full. After
// reset a clearing pass runs over both memories and no beat is taken until it
// ends. Out-of-region classify points and request code 3 give no result.
module voxel_background_model import vbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x, point_y, point_z, zero fill
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // voxel_index, zero fill
  output logic [0:0]  m_axis_tuser    // is_background
);

  `include "voxel_background_model_assert.svh"

  geom_t           geom_q;
  logic [CntW-1:0] thr_q;
  logic            init_done, bg;
  logic [IdxW-1:0] idx;
  vox_op_t         fq_data, qb_data;
  logic            q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.origin_x   <= '0;
      geom_q.origin_y   <= '0;
      geom_q.origin_z   <= '0;
      geom_q.resolution <= ResW'(100);
      geom_q.grid_x     <= GridW'(32);
      geom_q.grid_y     <= GridW'(32);
      geom_q.grid_z     <= GridW'(32);
      thr_q             <= CntW'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:   geom_q.origin_x   <= cfg_data_i;
        CFG_ORIGIN_Y:   geom_q.origin_y   <= cfg_data_i;
        CFG_ORIGIN_Z:   geom_q.origin_z   <= cfg_data_i;
        CFG_RESOLUTION: geom_q.resolution <= cfg_data_i[ResW-1:0];
        CFG_GRID_X:     geom_q.grid_x     <= cfg_data_i[GridW-1:0];
        CFG_GRID_Y:     geom_q.grid_y     <= cfg_data_i[GridW-1:0];
        CFG_GRID_Z:     geom_q.grid_z     <= cfg_data_i[GridW-1:0];
        CFG_THRESHOLD:  thr_q             <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  vbm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geom_i (geom_q),
    .en_i   (init_done),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .req_i  (s_axis_tuser),
    .px_i   (s_axis_tdata[19:0]),
    .py_i   (s_axis_tdata[39:20]),
    .pz_i   (s_axis_tdata[59:40]),
    .push_o (q_push),
    .op_o   (fq_data),
    .full_i (q_full)
  );

  vbm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (fq_data),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (qb_data),
    .empty_o(q_empty)
  );

  vbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .threshold_i(thr_q),
    .op_i       (qb_data),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .init_done_o(init_done),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .bg_o       (bg),
    .idx_o      (idx)
  );

  assign m_axis_tdata = {{(16 - IdxW){1'b0}}, idx};
  assign m_axis_tuser = bg;

  `VBM_ASSERT(a_no_beat_before_clear, s_axis_tvalid && s_axis_tready |-> init_done, "beat taken during clearing pass")
  `VBM_ASSERT(a_no_push_when_full, q_push |-> !q_full, "queue overflow")
  `VBM_ASSERT(a_no_pop_when_empty, q_pop |-> !q_empty, "queue underflow")
  `VBM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid, "result during reset")

endmodule

// ===== tb/tb_voxel_background_model.sv =====
// testbench for the voxel background model: directed table plus random points against a predictor
module tb_voxel_background_model;
  import vbm_pkg::*;

  // room for a full sweep per op that can be in flight
  localparam int unsigned SweepCycles = 4 * 32768 + 1000;

  typedef struct packed {
    logic                 bg;
    logic [IdxW-1:0]      idx;
  } verdict_t;

  typedef struct {
    req_e   req;
    int     x;
    int     y;
    int     z;
    bit     typed;
    bit     has_res;
    bit     bg;
    int     idx;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [19:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  voxel_background_model dut (.*);

  // predictor state
  longint org_x, org_y, org_z;
  int unsigned res_mm, gx, gy, gz, thr;
  logic [CntW-1:0] occ_count [MaxVoxels];
  bit frame_mark [MaxVoxels];
  verdict_t pending_q[$];
  int errors;
  bit idle_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sx20(logic [19:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint quant(longint c, longint o, int unsigned n);
    longint d;
    longint q;
    longint r;
    longint g;
    d = c - o;
    r = (res_mm == 0) ? 1 : res_mm;
    g = (n == 0) ? 1 : n;
    if (d <= 0) return 0;
    q = d / r;
    return (q > g - 1) ? g - 1 : q;
  endfunction

  function automatic int unsigned voxel_at(longint x, longint y, longint z);
    longint ex;
    longint ez;
    longint lin;
    ex = (gx == 0) ? 1 : gx;
    ez = (gz == 0) ? 1 : gz;
    lin = quant(y, org_y, gy) * ex * ez + quant(x, org_x, gx) * ez + quant(z, org_z, gz);
    return int'(lin % MaxVoxels);
  endfunction

  // updates the occupancy state; returns 1 with a verdict for an in-region classify
  function automatic bit occupancy_step(req_e req, longint x, longint y, longint z,
                                        output verdict_t v);
    int unsigned i;
    v = '0;
    case (req)
      REQ_LEARN: begin
        i = voxel_at(x, y, z);
        if (!frame_mark[i]) begin
          if (occ_count[i] != 16'hffff) occ_count[i]++;
          frame_mark[i] = 1'b1;
        end
        return 1'b0;
      end
      REQ_EOF: begin
        foreach (frame_mark[k]) frame_mark[k] = 1'b0;
        return 1'b0;
      end
      REQ_CLASSIFY: begin
        if (!(x > -2000 && (y > -5700 || z > 45000))) return 1'b0;
        i = voxel_at(x, y, z);
        v.bg = occ_count[i] > thr;
        v.idx = i[IdxW-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e r, longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= val[19:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      CFG_ORIGIN_X:   org_x = sx20(val[19:0]);
      CFG_ORIGIN_Y:   org_y = sx20(val[19:0]);
      CFG_ORIGIN_Z:   org_z = sx20(val[19:0]);
      CFG_RESOLUTION: res_mm = val[15:0];
      CFG_GRID_X:     gx = val[10:0];
      CFG_GRID_Y:     gy = val[10:0];
      CFG_GRID_Z:     gz = val[10:0];
      default:        thr = val[15:0];
    endcase
  endtask

  task automatic drain_results();
    wait (pending_q.size() == 0);
    repeat (SweepCycles) @(posedge clk_i);
  endtask

  // sends one point beat; queues either the typed verdict or the predicted one
  task automatic send_point(row_t r);
    verdict_t v;
    bit got;
    @(negedge clk_i);
    if (idle_en && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.req;
    s_axis_tdata <= {4'b0, r.z[19:0], r.y[19:0], r.x[19:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    got = occupancy_step(r.req, sx20(r.x[19:0]), sx20(r.y[19:0]), sx20(r.z[19:0]), v);
    if (r.typed) begin
      got = r.has_res;
      v.bg = r.bg;
      v.idx = r.idx[IdxW-1:0];
    end
    if (got) pending_q = {pending_q, v};
  endtask

  always @(negedge clk_i)
    m_axis_tready <= idle_en ? ($urandom_range(99) >= 27) : 1'b1;

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d bg=%0d", $time,
                 m_axis_tdata[IdxW-1:0], m_axis_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[IdxW-1:0] !== want.idx || m_axis_tdata[15] !== 1'b0) begin
          $display("%0t: voxel_index expected %0d actual %0d", $time, want.idx,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.bg) begin
          $display("%0t: is_background expected %0d actual %0d", $time, want.bg,
                   m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  function automatic int clamp20(longint c);
    if (c > 524287) return 524287;
    if (c < -524288) return -524288;
    return int'(c);
  endfunction

  // random coordinate: mostly inside the grid, some raw bits, some near region edges
  function automatic int pick_coord(longint o, int unsigned n, int edge_mm);
    int unsigned m;
    longint span;
    m = $urandom_range(99);
    span = longint'((res_mm == 0) ? 1 : res_mm) * ((n == 0) ? 1 : n);
    if (span > 400000) span = 400000;
    if (m < 70) return clamp20(o - 50 + longint'($urandom_range(0, int'(span) + 100)));
    if (m < 85) return int'(sx20($urandom()));
    return edge_mm + $urandom_range(0, 4) - 2;
  endfunction

  row_t dir_tab[] = '{
    '{REQ_CLASSIFY, 0, 0, 0, 1, 1, 0, 0},
    '{REQ_CLASSIFY, 524287, 524287, 524287, 1, 1, 0, 32767},
    '{REQ_CLASSIFY, -524288, 0, 0, 1, 0, 0, 0},
    '{REQ_CLASSIFY, -2000, 0, 0, 1, 0, 0, 0},
    '{REQ_CLASSIFY, -1999, -5700, 45000, 1, 0, 0, 0},
    '{REQ_CLASSIFY, -1999, -5700, 45001, 1, 1, 0, 31},
    '{REQ_CLASSIFY, -1999, -5699, 0, 1, 1, 0, 0},
    '{REQ_CLASSIFY, -1999, -524288, 524287, 1, 1, 0, 31},
    '{req_e'(2'd3), 100, 100, 100, 1, 0, 0, 0},
    '{REQ_LEARN, 150, 250, 350, 0, 0, 0, 0},
    '{REQ_LEARN, 199, 299, 399, 0, 0, 0, 0},
    '{REQ_CLASSIFY, 150, 250, 350, 0, 0, 0, 0},
    '{REQ_EOF, -1, -1, -1, 0, 0, 0, 0},
    '{REQ_LEARN, 150, 250, 350, 0, 0, 0, 0},
    '{REQ_EOF, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_LEARN, 150, 250, 350, 0, 0, 0, 0},
    '{REQ_EOF, 0, 0, 0, 0, 0, 0, 0},
    '{REQ_LEARN, -524288, -524288, -524288, 0, 0, 0, 0},
    '{REQ_LEARN, 524287, 524287, 524287, 0, 0, 0, 0},
    '{REQ_CLASSIFY, 150, 250, 350, 0, 0, 0, 0},
    '{REQ_CLASSIFY, 524287, 524287, 524287, 0, 0, 0, 0},
    '{req_e'(2'd3), -524288, 524287, -1, 0, 0, 0, 0}
  };

  initial begin
    row_t r;
    int unsigned m;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    errors = 0;
    idle_en = 1'b1;
    org_x = 0; org_y = 0; org_z = 0;
    res_mm = 100; gx = 32; gy = 32; gz = 32; thr = 5;
    foreach (occ_count[k]) begin
      occ_count[k] = '0;
      frame_mark[k] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) send_point(dir_tab[k]);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(CFG_ORIGIN_X, -1000); write_reg(CFG_ORIGIN_Y, -5000);
          write_reg(CFG_ORIGIN_Z, 0); write_reg(CFG_RESOLUTION, 200);
          write_reg(CFG_GRID_X, 4); write_reg(CFG_GRID_Y, 4);
          write_reg(CFG_GRID_Z, 4); write_reg(CFG_THRESHOLD, 1);
        end
        1: begin
          // grid product far past capacity, index wraps
          write_reg(CFG_ORIGIN_X, -1500); write_reg(CFG_ORIGIN_Y, -524288);
          write_reg(CFG_ORIGIN_Z, -524288); write_reg(CFG_RESOLUTION, 1);
          write_reg(CFG_GRID_X, 1024); write_reg(CFG_GRID_Y, 1024);
          write_reg(CFG_GRID_Z, 1024); write_reg(CFG_THRESHOLD, 0);
        end
        2: begin
          write_reg(CFG_ORIGIN_X, 524287); write_reg(CFG_ORIGIN_Y, 524287);
          write_reg(CFG_ORIGIN_Z, 524287); write_reg(CFG_RESOLUTION, 65535);
          write_reg(CFG_GRID_X, 0); write_reg(CFG_GRID_Y, 0);
          write_reg(CFG_GRID_Z, 0); write_reg(CFG_THRESHOLD, 65535);
        end
        3: begin
          // zero resolution acts as one
          write_reg(CFG_ORIGIN_X, 0); write_reg(CFG_ORIGIN_Y, 0);
          write_reg(CFG_ORIGIN_Z, 0); write_reg(CFG_RESOLUTION, 0);
          write_reg(CFG_GRID_X, 3); write_reg(CFG_GRID_Y, 5);
          write_reg(CFG_GRID_Z, 7); write_reg(CFG_THRESHOLD, 0);
        end
        default: begin
          write_reg(CFG_ORIGIN_X, -int'($urandom_range(0, 3000)));
          write_reg(CFG_ORIGIN_Y, -int'($urandom_range(0, 6000)));
          write_reg(CFG_ORIGIN_Z, -int'($urandom_range(0, 3000)));
          write_reg(CFG_RESOLUTION, $urandom_range(50, 400));
          write_reg(CFG_GRID_X, $urandom_range(2, 12));
          write_reg(CFG_GRID_Y, $urandom_range(2, 12));
          write_reg(CFG_GRID_Z, $urandom_range(2, 12));
          write_reg(CFG_THRESHOLD, $urandom_range(0, 2));
        end
      endcase
      for (int n = 0; n < 180; n++) begin
        idle_en = !(ph == 1 && n >= 40 && n < 160);
        if (ph == 3 && n == 90) wait (pending_q.size() == 0);
        m = $urandom_range(99);
        if (m < 50) r.req = REQ_LEARN;
        else if (m < 53) r.req = REQ_EOF;
        else if (m < 95) r.req = REQ_CLASSIFY;
        else r.req = req_e'(2'd3);
        r.x = pick_coord(org_x, gx, -2000);
        r.y = pick_coord(org_y, gy, -5700);
        r.z = pick_coord(org_z, gz, 45000);
        r.typed = 1'b0;
        r.has_res = 1'b0;
        r.bg = 1'b0;
        r.idx = 0;
        send_point(r);
      end
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end

    wait (pending_q.size() == 0);
    repeat (SweepCycles + 100) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("** voxel_background_model: PASSED **");
    end else begin
      $display("** voxel_background_model: FAILED **");
    end
    $finish;
  end

  initial begin
    #(64'd20 * 64'd20_000_000);
    $display("** voxel_background_model: FAILED **");
    $finish;
  end

endmodule
